@@ rtl/generational_index_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the generational index allocator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_INDEX_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_INDEX_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define GIA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GIA_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GIA_ASSERT(label, clk, rst_n, prop, msg)
`define GIA_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

@@ rtl/gia_pkg.sv @@
// ----------------------------------------------------------------------------
// gia_pkg
// Shared constants for the generational index allocator.
// ----------------------------------------------------------------------------
package gia_pkg;

	localparam int ENTRY_BITS = 32;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
	localparam logic [1:0] STATUS_NO_ACTIVE = 2'd2;

endpackage

@@ rtl/gia_slot_mem.sv @@
// ----------------------------------------------------------------------------
// gia_slot_mem
// Slot table: one write and one registered read per cycle. After reset a
// sweep writes every entry with generation zero and a link to the next slot, the last to itself.
// ----------------------------------------------------------------------------
module gia_slot_mem #(
	parameter int INDEX_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [INDEX_BITS-1:0]          rd_addr,
	output logic [gia_pkg::ENTRY_BITS-1:0] rd_data,
	input  logic                           wr_en,
	input  logic [INDEX_BITS-1:0]          wr_addr,
	input  logic [gia_pkg::ENTRY_BITS-1:0] wr_data,
	output logic                           clear_busy
);
	import gia_pkg::*;

	localparam int SLOT_COUNT = 1 << INDEX_BITS;
	localparam int GEN_BITS   = ENTRY_BITS - INDEX_BITS;

	logic [ENTRY_BITS-1:0] mem [SLOT_COUNT];
	logic [ENTRY_BITS-1:0] rd_data_q;
	logic                  clear_q;
	logic [INDEX_BITS-1:0] clr_idx_q;
	logic [INDEX_BITS-1:0] clr_link;
	logic                  clr_last;
	logic                  mem_we;
	logic [INDEX_BITS-1:0] mem_waddr;
	logic [ENTRY_BITS-1:0] mem_wdata;

	// the last slot links to itself
	assign clr_last = (clr_idx_q == {INDEX_BITS{1'b1}});
	assign clr_link = clr_last ? clr_idx_q : INDEX_BITS'(clr_idx_q + 1'b1);

	assign mem_we    = clear_q || wr_en;
	assign mem_waddr = clear_q ? clr_idx_q : wr_addr;
	assign mem_wdata = clear_q ? {{GEN_BITS{1'b0}}, clr_link} : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_idx_q <= '0;
		end else if (clear_q) begin
			clr_idx_q <= INDEX_BITS'(clr_idx_q + 1'b1);
			if (clr_last) begin
				clear_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data    = rd_data_q;
	assign clear_busy = clear_q;

endmodule

@@ rtl/generational_index_allocator.sv @@
// Each request is accepted, then does a read-modify-write of the slot table; the read is
// registered, as is the response. Each generation-wrap retry of an allocate repeats the
// read-modify-write, and a stalled earlier response holds the result back.
// New requests stall meanwhile. Reset: asynchronous, active low; then a clearing pass
// writes all 2^INDEX_BITS slot-table entries, with requests stalled until it finishes.
// ----------------------------------------------------------------------------
// generational_index_allocator
// Free-list slot allocator with per-slot generation counters kept in one
// synchronous slot table.
// ----------------------------------------------------------------------------
`include "generational_index_allocator_assert.svh"

module generational_index_allocator #(
	parameter int INDEX_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  logic                                   op,
	input  logic [31:0]                            free_handle,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	output logic [1:0]                             status,
	output logic [INDEX_BITS-1:0]                  slot_index,
	output logic [gia_pkg::ENTRY_BITS-INDEX_BITS-1:0] generation,
	output logic [INDEX_BITS:0]                    active_count
);
	import gia_pkg::*;

	localparam int GEN_BITS = ENTRY_BITS - INDEX_BITS;
	localparam logic [INDEX_BITS:0] SLOT_COUNT = {1'b1, {INDEX_BITS{1'b0}}};

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                  state_q;
	logic                  op_q;
	logic [INDEX_BITS-1:0] slot_q;
	logic [INDEX_BITS-1:0] head_q;
	logic                  empty_q;
	logic [INDEX_BITS:0]   count_q;
	logic [INDEX_BITS:0]   tries_q;

	logic                  rsp_valid_q;
	logic [1:0]            status_q;
	logic [INDEX_BITS-1:0] slot_index_q;
	logic [GEN_BITS-1:0]   generation_q;
	logic [INDEX_BITS:0]   active_count_q;

	logic                  clear_busy;
	logic                  req_xfer;
	logic                  out_free;
	logic                  rd_en;
	logic [INDEX_BITS-1:0] rd_addr;
	logic [ENTRY_BITS-1:0] rd_data;
	logic                  wr_en;
	logic [ENTRY_BITS-1:0] wr_data;

	logic [INDEX_BITS-1:0] ent_link;
	logic [GEN_BITS-1:0]   ent_gen;
	logic [GEN_BITS-1:0]   gen_inc;
	logic                  link_self;

	logic                  done;
	logic                  retry;
	logic                  fire;
	logic                  upd;
	logic [1:0]            res_status;
	logic [INDEX_BITS-1:0] res_slot;
	logic [GEN_BITS-1:0]   res_gen;
	logic [INDEX_BITS-1:0] head_n;
	logic                  empty_n;
	logic [INDEX_BITS:0]   count_n;

	assign req_stall = clear_busy || (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign ent_link  = rd_data[INDEX_BITS-1:0];
	assign ent_gen   = rd_data[ENTRY_BITS-1:INDEX_BITS];
	assign gen_inc   = GEN_BITS'(ent_gen + 1'b1);
	assign link_self = (ent_link == slot_q);

	always_comb begin
		done       = 1'b0;
		retry      = 1'b0;
		upd        = 1'b0;
		wr_data    = rd_data;
		res_status = STATUS_OK;
		res_slot   = '0;
		res_gen    = '0;
		head_n     = head_q;
		empty_n    = empty_q;
		count_n    = count_q;
		if (state_q == ST_EXEC) begin
			if (op_q == OP_ALLOC) begin
				if (empty_q || count_q[INDEX_BITS]) begin
					done       = 1'b1;
					res_status = STATUS_NO_SLOT;
				end else begin
					upd     = 1'b1;
					wr_data = {gen_inc, slot_q};
					if (link_self) begin
						empty_n = 1'b1;
					end else begin
						head_n = ent_link;
					end
					if (gen_inc != '0) begin
						done     = 1'b1;
						res_slot = slot_q;
						res_gen  = gen_inc;
						count_n  = (INDEX_BITS + 1)'(count_q + 1'b1);
					end else if (link_self || (tries_q == {(INDEX_BITS + 1){1'b1}})) begin
						// wrapped slot dropped and nothing left to try
						done       = 1'b1;
						res_status = STATUS_NO_SLOT;
					end else begin
						retry = 1'b1;
					end
				end
			end else begin
				done = 1'b1;
				if (count_q == '0) begin
					res_status = STATUS_NO_ACTIVE;
				end else begin
					upd      = 1'b1;
					wr_data  = {ent_gen, (empty_q ? slot_q : head_q)};
					head_n   = slot_q;
					empty_n  = 1'b0;
					count_n  = (INDEX_BITS + 1)'(count_q - 1'b1);
					res_slot = slot_q;
				end
			end
		end
	end

	// hold the step while a finished result cannot be loaded
	assign fire  = retry || (done && out_free);
	assign wr_en = fire && upd;

	assign rd_en   = req_xfer || (fire && retry);
	assign rd_addr = (state_q == ST_EXEC) ? ent_link :
		((op == OP_FREE) ? free_handle[INDEX_BITS-1:0] : head_q);

	gia_slot_mem #(
		.INDEX_BITS (INDEX_BITS)
	) u_slot_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (slot_q),
		.wr_data    (wr_data),
		.clear_busy (clear_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			empty_q     <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_xfer) begin
				state_q <= ST_EXEC;
			end else if (fire && done) begin
				state_q <= ST_IDLE;
			end
			if (fire) begin
				head_q  <= head_n;
				empty_q <= empty_n;
				count_q <= count_n;
			end
			if (fire && done) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q    <= op;
			slot_q  <= (op == OP_FREE) ? free_handle[INDEX_BITS-1:0] : head_q;
			tries_q <= '0;
		end else if (fire && retry) begin
			// advance to the next free slot
			slot_q  <= ent_link;
			tries_q <= (INDEX_BITS + 1)'(tries_q + 1'b1);
		end
		if (fire && done) begin
			status_q       <= res_status;
			slot_index_q   <= res_slot;
			generation_q   <= res_gen;
			active_count_q <= count_n;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign slot_index   = slot_index_q;
	assign generation   = generation_q;
	assign active_count = active_count_q;

	`GIA_ASSERT(a_count_bound, clk, arst_n, count_q <= SLOT_COUNT, "active count above slot count")
	`GIA_ASSERT(a_alloc_counts, clk, arst_n, (fire && done && op_q == OP_ALLOC && res_status == STATUS_OK) |=> (count_q == $past(count_q) + 1'b1), "allocate did not raise count")
	`GIA_ASSERT(a_no_retry_on_free, clk, arst_n, (state_q == ST_EXEC && op_q == OP_FREE) |-> !retry, "free entered retry")
	`GIA_ASSERT_NR(a_clear_stalls, clk, clear_busy |-> req_stall, "request taken during table clear")

endmodule

@@ bench/generational_index_allocator_checker.sv @@
// ----------------------------------------------------------------------------
// generational_index_allocator_checker
// Watches the request and response channels of the allocator, keeps its own
// copy of the slot table, free list and active count, and checks every
// response transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
module generational_index_allocator_checker #(
	parameter int INDEX_BITS = 10
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      req_valid,
	input  logic                                      req_stall,
	input  logic                                      op,
	input  logic [31:0]                               free_handle,
	input  logic                                      rsp_valid,
	input  logic                                      rsp_stall,
	input  logic [1:0]                                status,
	input  logic [INDEX_BITS-1:0]                     slot_index,
	input  logic [gia_pkg::ENTRY_BITS-INDEX_BITS-1:0] generation,
	input  logic [INDEX_BITS:0]                       active_count,
	output int                                        mismatches,
	output int                                        outstanding
);

	import gia_pkg::*;

	localparam int SLOT_COUNT = 1 << INDEX_BITS;
	localparam int GEN_BITS   = ENTRY_BITS - INDEX_BITS;

	typedef struct packed {
		logic [1:0]            status;
		logic [INDEX_BITS-1:0] slot;
		logic [GEN_BITS-1:0]   gen;
		logic [INDEX_BITS:0]   count;
	} slot_result_t;

	logic [ENTRY_BITS-1:0] slot_table [SLOT_COUNT];
	logic [INDEX_BITS-1:0] head;
	logic                  list_empty;
	int                    in_use;
	slot_result_t          pending_results [$];
	int                    err_total;

	function automatic slot_result_t make_result(logic [1:0] st, logic [INDEX_BITS-1:0] slot,
			logic [GEN_BITS-1:0] gen);
		slot_result_t r;
		r.status = st;
		r.slot   = slot;
		r.gen    = gen;
		r.count  = (INDEX_BITS+1)'(in_use);
		return r;
	endfunction

	// Pop the head and bump its generation; a slot whose generation wraps
	// to zero stays off the list and the pop repeats.
	function automatic slot_result_t predict_allocate();
		logic [INDEX_BITS-1:0] slot;
		logic [INDEX_BITS-1:0] nxt;
		logic [GEN_BITS-1:0]   gen;
		int                    tries;
		if (list_empty || in_use >= SLOT_COUNT)
			return make_result(STATUS_NO_SLOT, '0, '0);
		for (tries = 0; tries < 2 * SLOT_COUNT && !list_empty; tries++) begin
			slot = head;
			nxt  = slot_table[slot][INDEX_BITS-1:0];
			if (nxt == slot)
				list_empty = 1'b1;
			else
				head = nxt;
			gen = slot_table[slot][ENTRY_BITS-1:INDEX_BITS] + 1'b1;
			slot_table[slot] = {gen, slot};
			if (gen != '0) begin
				in_use++;
				return make_result(STATUS_OK, slot, gen);
			end
		end
		return make_result(STATUS_NO_SLOT, '0, '0);
	endfunction

	function automatic slot_result_t predict_free(logic [31:0] handle);
		logic [INDEX_BITS-1:0] slot;
		slot = handle[INDEX_BITS-1:0];
		if (in_use == 0)
			return make_result(STATUS_NO_ACTIVE, '0, '0);
		// an empty list restarts with this slot linked to itself
		if (list_empty) begin
			head       = slot;
			list_empty = 1'b0;
		end
		slot_table[slot][INDEX_BITS-1:0] = head;
		head = slot;
		in_use--;
		return make_result(STATUS_OK, slot, '0);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_result_t got;
		slot_result_t want;
		int           i;
		if (!arst_n) begin
			for (i = 0; i < SLOT_COUNT; i++)
				slot_table[i] = (i + 1 < SLOT_COUNT) ? ENTRY_BITS'(i + 1) : ENTRY_BITS'(i);
			head       = '0;
			list_empty = 1'b0;
			in_use     = 0;
			pending_results.delete();
			err_total  = 0;
		end else begin
			// retire the response first so a new request cannot pair with it
			if (rsp_valid && !rsp_stall) begin
				got = '{status, slot_index, generation, active_count};
				if (pending_results.size() == 0) begin
					if (err_total < 10)
						$display("%0t: response transfer with nothing pending: status %0d slot %0d gen %0d count %0d",
							$time, got.status, got.slot, got.gen, got.count);
					err_total++;
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.slot !== want.slot ||
							got.gen !== want.gen || got.count !== want.count) begin
						if (err_total < 10)
							$display("%0t: mismatch exp status %0d slot %0d gen %0d count %0d, got status %0d slot %0d gen %0d count %0d",
								$time, want.status, want.slot, want.gen, want.count,
								got.status, got.slot, got.gen, got.count);
						err_total++;
					end
				end
			end
			if (req_valid && !req_stall)
				pending_results.push_back(op == OP_ALLOC ? predict_allocate() :
					predict_free(free_handle));
		end
		mismatches  <= err_total;
		outstanding <= pending_results.size();
	end

endmodule

@@ bench/generational_index_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// generational_index_allocator_tb
// Drives allocate and free transfers into the allocator with random gaps and
// response stalls: a short directed run over the empty and idle cases, then
// a fill-heavy run that exhausts the slots and a mixed run with stray frees.
// ----------------------------------------------------------------------------
module generational_index_allocator_tb;

	import gia_pkg::*;

	localparam int INDEX_BITS  = 10;
	localparam int GEN_BITS    = ENTRY_BITS - INDEX_BITS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int FILL_ITEMS  = 1150;
	localparam int MIX_ITEMS   = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	logic                  op;
	logic [31:0]           free_handle;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic [1:0]            status;
	logic [INDEX_BITS-1:0] slot_index;
	logic [GEN_BITS-1:0]   generation;
	logic [INDEX_BITS:0]   active_count;
	int                    mismatches;
	int                    outstanding;
	logic                  calm;
	int                    cycles = 0;
	logic [INDEX_BITS-1:0] held_slots [$];

	generational_index_allocator #(.INDEX_BITS(INDEX_BITS)) uut (.*);

	generational_index_allocator_checker #(.INDEX_BITS(INDEX_BITS)) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_stall <= arst_n && !calm && ($urandom_range(99) < 15);
	end

	// Track handed-out slots so most frees return a live one; also the watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("generational_index_allocator_tb: done, errors");
			$finish;
		end
		if (arst_n && rsp_valid && !rsp_stall && status == STATUS_OK && generation != '0)
			held_slots.push_back(slot_index);
	end

	task automatic transfer_request(input logic kind, input logic [31:0] handle);
		while (!calm && $urandom_range(99) < 15) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		op          <= kind;
		free_handle <= handle;
		do @(posedge clk); while (req_stall);
	endtask

	// Free a held slot with random upper handle bits, or now and then a stray one.
	task automatic send_free(input int stray_pct);
		int          idx;
		logic [31:0] handle;
		handle = $urandom();
		if (held_slots.size() != 0 && $urandom_range(99) >= stray_pct) begin
			idx = $urandom_range(held_slots.size() - 1);
			handle[INDEX_BITS-1:0] = held_slots[idx];
			held_slots.delete(idx);
		end
		transfer_request(OP_FREE, handle);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		int alloc_pct;
		int stray_pct;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		op          = OP_ALLOC;
		free_handle = '0;
		calm        = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// nothing active yet: both frees must be refused
		transfer_request(OP_FREE, 32'hFFFF_FFFF);
		transfer_request(OP_FREE, 32'h0000_0000);
		transfer_request(OP_ALLOC, 32'hFFFF_FFFF);
		transfer_request(OP_ALLOC, 32'h0000_0000);
		transfer_request(OP_ALLOC, $urandom());
		// upper handle bits set: only the slot bits may count
		transfer_request(OP_FREE, 32'hFFFF_FC01);
		transfer_request(OP_ALLOC, $urandom());
		transfer_request(OP_FREE, 32'hAAAA_A802);
		transfer_request(OP_ALLOC, $urandom());
		transfer_request(OP_FREE, 32'h0000_0000);
		transfer_request(OP_FREE, 32'h5555_5401);
		transfer_request(OP_FREE, 32'h0000_0002);
		transfer_request(OP_FREE, 32'h5555_5555);
		wait_drained();
		// everything was returned above
		held_slots.delete();

		// Fill until the slots run out, then churn with stray and repeated frees.
		for (n = 0; n < FILL_ITEMS + MIX_ITEMS; n++) begin
			calm <= (n >= 300 && n < 600);
			alloc_pct = (n < FILL_ITEMS) ? 96 : 45;
			stray_pct = (n < FILL_ITEMS) ? 3 : 25;
			if ($urandom_range(99) < alloc_pct)
				transfer_request(OP_ALLOC, $urandom());
			else
				send_free(stray_pct);
		end
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("generational_index_allocator_tb: done, clean");
		end else begin
			$display("generational_index_allocator_tb: done, errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gia_pkg.sv
rtl/gia_slot_mem.sv
rtl/generational_index_allocator.sv
bench/generational_index_allocator_checker.sv
bench/generational_index_allocator_tb.sv
